[hdl/miller_rabin_prime_test_64_core_macros.svh]
// assertion macros for the miller-rabin core checker
// no dependencies
`ifndef MILLER_RABIN_PRIME_TEST_64_CORE_MACROS_SVH
`define MILLER_RABIN_PRIME_TEST_64_CORE_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define MR_ASSERT_IMPL(label, clk, rst_n, lhs, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) else $error(msg);
// next-cycle implication
`define MR_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) else $error(msg);
`endif

[hdl/mrp_pkg.sv]
// package for the miller-rabin core: widths and witness base table
// no dependencies
package mrp_pkg;
	localparam int unsigned CandW = 63;
	localparam int unsigned WordW = 64;
	localparam int unsigned BaseCount = 7;
	localparam int unsigned BaseIdxW = 3;
	localparam int unsigned BitIdxW = 6;

	function automatic logic [WordW-1:0] witness_base(input logic [BaseIdxW-1:0] idx);
		logic [WordW-1:0] r;
		case (idx)
			3'd0: r = 64'd2;
			3'd1: r = 64'd450775;
			3'd2: r = 64'd1795265022;
			3'd3: r = 64'd9780504;
			3'd4: r = 64'd28178;
			3'd5: r = 64'd9375;
			3'd6: r = 64'd325;
			default: r = 64'd2;
		endcase
		return r;
	endfunction
endpackage

[hdl/miller_rabin_prime_test_64_core.sv]
// top level of the deterministic miller-rabin primality test, 63-bit candidates
// depends on mrp_pkg and mrp_mulmod
//
// input channel: candidate with in_valid / in_stall; the core raises in_stall
// while a test runs. output channel: is_prime with out_valid / out_stall.
// one candidate gives exactly one result.
// values of 2 or less and even values are settled in ST_CHECK and offered from ST_OUT.
// otherwise each base takes a reduction (one multiply of 1 by the base) then up
// to two multiplies per exponent bit and up to s squarings, at most 126
// multiplies per base; every multiply goes through the shared bit-serial unit.
// reset empties the core; a held result waits while out_stall is high, and a
// new candidate is not taken until the result has been transferred.
module miller_rabin_prime_test_64_core import mrp_pkg::*; #(
	parameter int unsigned NUM_BASES = 7
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [CandW-1:0] candidate,
	output logic            out_valid,
	input  logic            out_stall,
	output logic            is_prime
);
	localparam int unsigned NbEff = (NUM_BASES > BaseCount) ? BaseCount : NUM_BASES;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CHECK, ST_SPLIT, ST_BASE, ST_RED, ST_PMUL, ST_PSQ, ST_PNEXT,
		ST_SQ, ST_SQCHK, ST_NEXTB, ST_OUT
	} state_t;

	state_t state_q;
	logic [WordW-1:0] n_q, d_q, e_q, acc_q, pb_q, c_q;
	logic [BitIdxW-1:0] s_q, j_q;
	logic [BaseIdxW-1:0] bi_q;
	logic prime_q, wait_q;

	logic mm_start, mm_done;
	logic [WordW-1:0] mm_a, mm_b, mm_res;

	mrp_mulmod u_mul (
		.clk(clk), .arst_n(arst_n), .start(mm_start), .a(mm_a), .b(mm_b),
		.m(n_q), .done(mm_done), .result(mm_res)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign is_prime = prime_q;

	always_comb begin
		mm_start = 1'b0;
		mm_a = acc_q;
		mm_b = pb_q;
		if (!wait_q) begin
			unique case (state_q)
				ST_RED: begin
					mm_start = 1'b1; mm_a = 64'd1; mm_b = witness_base(bi_q);
				end
				ST_PMUL: begin
					mm_start = 1'b1; mm_a = acc_q; mm_b = pb_q;
				end
				ST_PSQ: begin
					mm_start = 1'b1; mm_a = pb_q; mm_b = pb_q;
				end
				ST_SQ: begin
					mm_start = (j_q != s_q); mm_a = c_q; mm_b = c_q;
				end
				default: mm_start = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wait_q <= 1'b0;
			prime_q <= 1'b0;
		end else begin
			if (mm_start) wait_q <= 1'b1;
			unique case (state_q)
				ST_IDLE: if (in_valid) begin
					n_q <= {1'b0, candidate};
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (n_q <= 64'd2 || !n_q[0]) begin
						prime_q <= (n_q == 64'd2);
						state_q <= ST_OUT;
					end else begin
						d_q <= n_q - 64'd1;
						s_q <= '0;
						bi_q <= '0;
						prime_q <= 1'b1;
						state_q <= ST_SPLIT;
					end
				end
				ST_SPLIT: begin
					if (!d_q[0]) begin
						d_q <= d_q >> 1;
						s_q <= s_q + 1'b1;
					end else begin
						state_q <= ST_BASE;
					end
				end
				ST_BASE: begin
					if (32'(bi_q) >= NbEff) state_q <= ST_OUT;
					else state_q <= ST_RED;
				end
				ST_RED: if (mm_done) begin
					wait_q <= 1'b0;
					if (mm_res == '0) begin
						state_q <= ST_NEXTB;
					end else begin
						pb_q <= mm_res;
						acc_q <= 64'd1;
						e_q <= d_q;
						state_q <= ST_PNEXT;
					end
				end
				ST_PNEXT: begin
					if (e_q == '0) begin
						c_q <= acc_q;
						j_q <= '0;
						state_q <= ST_SQ;
					end else if (e_q[0]) begin
						state_q <= ST_PMUL;
					end else begin
						state_q <= ST_PSQ;
					end
				end
				ST_PMUL: if (mm_done) begin
					wait_q <= 1'b0;
					acc_q <= mm_res;
					state_q <= ST_PSQ;
				end
				ST_PSQ: if (mm_done) begin
					wait_q <= 1'b0;
					pb_q <= mm_res;
					e_q <= e_q >> 1;
					state_q <= ST_PNEXT;
				end
				ST_SQ: begin
					if (j_q == s_q) begin
						if (c_q != 64'd1) begin
							prime_q <= 1'b0;
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_NEXTB;
						end
					end else if (mm_done) begin
						wait_q <= 1'b0;
						acc_q <= mm_res;
						state_q <= ST_SQCHK;
					end
				end
				ST_SQCHK: begin
					if (acc_q == 64'd1 && c_q != 64'd1 && c_q != n_q - 64'd1) begin
						prime_q <= 1'b0;
						state_q <= ST_OUT;
					end else begin
						c_q <= acc_q;
						j_q <= j_q + 1'b1;
						state_q <= ST_SQ;
					end
				end
				ST_NEXTB: begin
					bi_q <= bi_q + 1'b1;
					state_q <= ST_BASE;
				end
				ST_OUT: if (!out_stall) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

[hdl/mrp_mulmod.sv]
// shared modular multiplier: a*b mod m, one bit of b per cycle from bit 62 down
// also reduces a value mod m (a = 1, b = the value) in the same bit-serial form with conditional subtraction
// depends on mrp_pkg
module mrp_mulmod import mrp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WordW-1:0] a,
	input  logic [WordW-1:0] b,
	input  logic [WordW-1:0] m,
	output logic             done,
	output logic [WordW-1:0] result
);
	logic [WordW-1:0] acc_q, a_q, b_q, m_q;
	logic [BitIdxW-1:0] bit_q;
	logic busy_q;
	logic [WordW-1:0] dbl, dbl_r, add, add_r;

	always_comb begin
		dbl = {acc_q[WordW-2:0], 1'b0};
		dbl_r = (dbl >= m_q) ? dbl - m_q : dbl;
		add = dbl_r + a_q;
		add_r = (add >= m_q) ? add - m_q : add;
		if (!b_q[bit_q]) add_r = dbl_r;
	end

	assign result = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			bit_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				bit_q <= BitIdxW'(CandW - 1);
				acc_q <= '0;
				a_q <= a;
				b_q <= b;
				m_q <= m;
			end else if (busy_q) begin
				acc_q <= add_r;
				if (bit_q == '0) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end else begin
					bit_q <= bit_q - 1'b1;
				end
			end
		end
	end
endmodule

[hdl/mrp_checker.sv]
// port-level checker for the miller-rabin core, bound to the top level
// depends on miller_rabin_prime_test_64_core_macros.svh
`include "miller_rabin_prime_test_64_core_macros.svh"
module mrp_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic is_prime
);
	`MR_ASSERT_NEXT(a_busy_after_take, clk, arst_n, in_valid && !in_stall, in_stall, "not busy after transfer")
	`MR_ASSERT_IMPL(a_out_only_busy, clk, arst_n, out_valid, in_stall, "result while ready")
	`MR_ASSERT_NEXT(a_out_holds, clk, arst_n, out_valid && out_stall, out_valid && $stable(is_prime), "result dropped")
endmodule

bind miller_rabin_prime_test_64_core mrp_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .is_prime(is_prime)
);

[sim/tb_top.sv]
// self-checking testbench for miller_rabin_prime_test_64_core: primality of 63-bit candidates
// depends on mrp_pkg and the core rtl; predictor and scoreboard are local to this file
module tb_top import mrp_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [WordW-1:0] word_t;

	class primality_scoreboard;
		bit verdicts[$];
		int errors;
		int checked;
		int primes_seen;

		function word_t mulmod(word_t a, word_t b, word_t m);
			word_t acc;
			acc = 0;
			for (int i = 62; i >= 0; i--) begin
				acc = acc << 1;
				if (acc >= m) acc -= m;
				if (b[i]) begin
					acc += a;
					if (acc >= m) acc -= m;
				end
			end
			return acc;
		endfunction

		function word_t powmod(word_t b, word_t e, word_t m);
			word_t acc;
			acc = 1 % m;
			while (e != 0) begin
				if (e[0]) acc = mulmod(acc, b, m);
				b = mulmod(b, b, m);
				e = e >> 1;
			end
			return acc;
		endfunction

		function bit predict_prime(word_t n);
			word_t d, c, sq, a;
			int s;
			if (n <= 2 || !n[0]) return n == 2;
			d = n - 1;
			s = 0;
			while (!d[0]) begin
				d = d >> 1;
				s++;
			end
			for (int i = 0; i < BaseCount; i++) begin
				a = witness_base(3'(i)) % n;
				if (a == 0) continue;
				c = powmod(a, d, n);
				for (int j = 0; j < s; j++) begin
					sq = mulmod(c, c, n);
					if (sq == 1 && c != 1 && c != n - 1) return 0;
					c = sq;
				end
				if (c != 1) return 0;
			end
			return 1;
		endfunction

		function void note_candidate(logic [CandW-1:0] cand);
			verdicts = {verdicts, predict_prime({1'b0, cand})};
		endfunction

		function void check_verdict(logic got);
			bit want;
			if (verdicts.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %b", $time, got);
				errors++;
				return;
			end
			want = verdicts.pop_front();
			checked++;
			if (want) primes_seen++;
			if (got !== want) begin
				$display("%0t: is_prime mismatch, expected %b, actual %b", $time, want, got);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic [CandW-1:0] candidate = 0;
	logic out_stall = 0;
	logic in_stall, out_valid, is_prime;
	int send_idle = 0, recv_idle = 0;
	int unsigned cycles = 0;
	bit timed_out = 0;
	primality_scoreboard sb = new();

	miller_rabin_prime_test_64_core dut (.*);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (out_valid && !out_stall) sb.check_verdict(is_prime);
		out_stall <= ($urandom_range(99) < recv_idle);
	end

	task automatic send_candidate(logic [CandW-1:0] cand);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		candidate <= cand;
		do @(posedge clk); while (in_stall);
		sb.note_candidate(cand);
	endtask

	function automatic logic [CandW-1:0] random_candidate();
		logic [CandW-1:0] v;
		v = 63'({$urandom, $urandom});
		case ($urandom_range(5))
			0: v = v >> $urandom_range(62);
			1: v[0] = 0;
			2: v = 63'($urandom_range(5000)) | 63'd1;
			default: v[0] = 1;
		endcase
		return v;
	endfunction

	localparam logic [CandW-1:0] directed [22] = '{
		63'd0, 63'd1, 63'd2, 63'd3, 63'd4, 63'd5, 63'd9, 63'd561,
		63'd13, 63'd19, 63'd23, 63'd1_795_265_022 + 63'd0, 63'd2_152_302_898_747,
		63'd3_215_031_751, 63'd341_550_071_728_321, 63'h7FFF_FFFF_FFFF_FFFF,
		63'h7FFF_FFFF_FFFF_FFE7, 63'h7FFF_FFFF_FFFF_FFFE, 63'h5555_5555_5555_5555,
		63'h2AAA_AAAA_AAAA_AAAB, 63'd251, 63'd1_000_000_007};

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (directed[i]) send_candidate(directed[i]);
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 15 : (ph == 1) ? 47 : 0;
			recv_idle = (ph == 0) ? 47 : (ph == 1) ? 15 : 0;
			repeat (26) send_candidate(random_candidate());
		end
		in_valid <= 0;
		while (sb.verdicts.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("checked %0d verdicts, %0d of them prime, over three idling phases",
			sb.checked, sb.primes_seen);
		if (sb.errors == 0 && !timed_out)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	always @(posedge clk)
		if (cycles == 40_000_000 && !timed_out) begin
			timed_out <= 1;
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
endmodule
